// ----- rtl/core/swm_pkg.sv -----
// Shared constants, codes and word conversion helpers for the stack with
// middle access. Used by stack_with_middle_access_core; no dependencies.

package swm_pkg;

  // Storage geometry.
  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W    = $clog2(DEPTH + 1);

  // Fixed field widths of the stream payload.
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int VALUE_W     = 32;
  localparam int NEW_COUNT_W = 7;
  localparam int OUT_DATA_W  = ((VALUE_W + NEW_COUNT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_DATA_W - VALUE_W - NEW_COUNT_W;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH     = 2'd0,
    OP_POP      = 2'd1,
    OP_READ_MID = 2'd2,
    OP_DEL_MID  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Sign-extend the 32-bit request value, then keep DATA_WIDTH bits.
  function automatic logic [DATA_WIDTH-1:0] word_in(input logic [VALUE_W-1:0] v);
    logic signed [63:0] t;
    t = 64'(signed'(v));
    return t[DATA_WIDTH-1:0];
  endfunction

  // Sign-extend a stored word from DATA_WIDTH bits, then keep 32 bits.
  function automatic logic [VALUE_W-1:0] word_out(input logic [DATA_WIDTH-1:0] w);
    logic signed [63:0] t;
    t = 64'(signed'(w));
    return t[VALUE_W-1:0];
  endfunction

endpackage

// ----- rtl/core/swm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependencies.

module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/stack_with_middle_access_core.sv -----
// Stack with middle access: push, pop, read middle and delete middle.
// Push and any request that reports empty or full go straight to the result stage;
// pop and read middle first wait for one RAM read. Delete middle reads the middle
// entry, then moves each entry above it down by one, up to DEPTH/2 - 1 entries, the single
// RAM read and write port moving one entry each cycle. One request at a time.
// Reset (rst, synchronous) empties the stack; the RAM contents are not cleared.

module stack_with_middle_access_core (
  input  logic                            clk,
  input  logic                            rst,
  // Request: tdata = push_value[31:0]; tuser = operation[1:0].
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [swm_pkg::VALUE_W-1:0]     s_tdata,
  input  logic [swm_pkg::OP_W-1:0]        s_tuser,
  // Result: tdata = result_value[31:0], new_count[38:32], zero pad[39];
  // tuser = status[1:0].
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [swm_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic [swm_pkg::STATUS_W-1:0]    m_tuser
);

  import swm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_RDWAIT  = 5'b00010,
    S_MIDWAIT = 5'b00100,
    S_SHIFT   = 5'b01000,
    S_FINISH  = 5'b10000
  } state_t;

  state_t               state, state_next;
  logic [COUNT_W-1:0]   count, count_next;
  logic [ADDR_W-1:0]    ptr, ptr_next;
  status_t              res_status, res_status_next;
  logic [VALUE_W-1:0]   res_value, res_value_next;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic [COUNT_W-1:0]   mid;
  logic [COUNT_W-1:0]   count_dec;
  logic [COUNT_W:0]     ptr_p1;
  logic [COUNT_W:0]     ptr_p2;
  logic                 out_free;

  assign mid       = count >> 1;
  assign count_dec = count - COUNT_W'(1);
  assign ptr_p1    = (COUNT_W + 1)'(ptr) + (COUNT_W + 1)'(1);
  assign ptr_p2    = (COUNT_W + 1)'(ptr) + (COUNT_W + 1)'(2);
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE);

  // Entry storage.
  swm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer: decodes a request, then steps the RAM through reads and moves.
  always_comb begin
    state_next      = state;
    count_next      = count;
    ptr_next        = ptr;
    res_status_next = res_status;
    res_value_next  = res_value;
    ram_we          = 1'b0;
    ram_waddr       = ptr;
    ram_wdata       = ram_rdata;
    ram_raddr       = ptr;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          res_status_next = ST_OK;
          res_value_next  = '0;
          state_next      = S_FINISH;
          if (op_t'(s_tuser) == OP_PUSH) begin
            if (count == COUNT_W'(DEPTH)) begin
              res_status_next = ST_FULL;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = count[ADDR_W-1:0];
              ram_wdata  = word_in(s_tdata);
              count_next = count + COUNT_W'(1);
            end
          end else if (count == '0) begin
            res_status_next = ST_EMPTY;
          end else begin
            case (op_t'(s_tuser))
              OP_POP: begin
                ram_raddr  = count_dec[ADDR_W-1:0];
                count_next = count_dec;
                state_next = S_RDWAIT;
              end
              OP_READ_MID: begin
                ram_raddr  = mid[ADDR_W-1:0];
                state_next = S_RDWAIT;
              end
              OP_DEL_MID: begin
                ram_raddr  = mid[ADDR_W-1:0];
                ptr_next   = mid[ADDR_W-1:0];
                state_next = S_MIDWAIT;
              end
              default: begin
                state_next = S_FINISH;
              end
            endcase
          end
        end
      end

      S_RDWAIT: begin
        res_value_next = word_out(ram_rdata);
        state_next     = S_FINISH;
      end

      // The middle entry has been read; start moving the entries above it.
      S_MIDWAIT: begin
        res_value_next = word_out(ram_rdata);
        if (ptr_p1 < (COUNT_W + 1)'(count)) begin
          ram_raddr  = ptr_p1[ADDR_W-1:0];
          state_next = S_SHIFT;
        end else begin
          count_next = count_dec;
          state_next = S_FINISH;
        end
      end

      // Each cycle writes entry ptr+1 down to ptr and fetches the next one.
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr;
        ram_wdata = ram_rdata;
        ptr_next  = ptr_p1[ADDR_W-1:0];
        if (ptr_p2 < (COUNT_W + 1)'(count)) begin
          ram_raddr = ptr_p2[ADDR_W-1:0];
        end else begin
          count_next = count_dec;
          state_next = S_FINISH;
        end
      end

      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
    if (state == S_FINISH && out_free) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, NEW_COUNT_W'(count), res_value};
      m_tuser <= res_status;
    end
  end

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for stack_with_middle_access_core: directed and random requests,
// each result compared against an in-bench model of the stack contents.
// Depends on swm_pkg and stack_with_middle_access_core.

module tb;
  import swm_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [VALUE_W-1:0]    s_tdata;
  logic [OP_W-1:0]       s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]   m_tuser;

  typedef struct {
    status_t              status;
    logic [VALUE_W-1:0]   value;
    logic [NEW_COUNT_W-1:0] count;
  } stack_outcome_t;

  // Shadow copy of the stack and the outcomes still owed by the block.
  logic [DATA_WIDTH-1:0] shadow_words [DEPTH];
  int                    shadow_count;
  stack_outcome_t        pending_outcomes [$];

  int mismatch_count;
  bit use_gaps;
  int hold_cycles;

  stack_with_middle_access_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit well beyond the slowest correct run.
  initial begin
    #3000000;
    $display("stack_with_middle_access_core verification failed");
    $finish;
  end

  // Apply one operation to the shadow stack and return the outcome it owes.
  function automatic stack_outcome_t apply_stack_op(op_t op, logic [VALUE_W-1:0] v);
    stack_outcome_t r;
    logic [63:0] wide;
    logic [DATA_WIDTH-1:0] w;
    int idx;
    int i;
    int b;
    r.status = ST_OK;
    r.value  = '0;
    if (op == OP_PUSH) begin
      if (shadow_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        wide = {{32{v[VALUE_W-1]}}, v};
        shadow_words[shadow_count] = wide[DATA_WIDTH-1:0];
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      idx = (op == OP_POP) ? shadow_count - 1 : shadow_count / 2;
      w = shadow_words[idx];
      // The stored word reads back sign-extended from its own width.
      for (b = 0; b < VALUE_W; b++) begin
        r.value[b] = (b < DATA_WIDTH) ? w[b] : w[DATA_WIDTH-1];
      end
      if (op == OP_DEL_MID) begin
        for (i = idx; i + 1 < shadow_count; i++) begin
          shadow_words[i] = shadow_words[i+1];
        end
      end
      if (op != OP_READ_MID) begin
        shadow_count--;
      end
    end
    r.count = NEW_COUNT_W'(shadow_count);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // Offer one request, after a random gap when gaps are enabled, and wait until it is taken.
  task automatic send_request(op_t op, logic [VALUE_W-1:0] v);
    int gap;
    gap = use_gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    pending_outcomes.push_back(apply_stack_op(op, v));
  endtask

  // Random request mix; push_pct sets how often a push is chosen.
  task automatic run_random_mix(int n, int push_pct);
    int k;
    logic [VALUE_W-1:0] v;
    op_t op;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0:       v = 32'h8000_0000;
        1:       v = 32'h7fff_ffff;
        2:       v = 32'hffff_ffff;
        3:       v = 32'h0000_0000;
        default: v = $urandom();
      endcase
      if ($urandom_range(0, 99) < push_pct) begin
        op = OP_PUSH;
      end else begin
        case ($urandom_range(0, 2))
          0:       op = OP_POP;
          1:       op = OP_READ_MID;
          default: op = OP_DEL_MID;
        endcase
      end
      send_request(op, v);
    end
  endtask

  // Pop, read middle and delete middle with nothing stored.
  task automatic test_empty_stack();
    send_request(OP_POP, $urandom());
    send_request(OP_READ_MID, $urandom());
    send_request(OP_DEL_MID, $urandom());
  endtask

  // Extreme values pushed, then a middle read or delete at every size down to empty, with pops between.
  task automatic test_middle_access();
    send_request(OP_PUSH, 32'h8000_0000);
    send_request(OP_PUSH, 32'h7fff_ffff);
    send_request(OP_PUSH, 32'hffff_ffff);
    send_request(OP_PUSH, 32'h0000_0000);
    send_request(OP_PUSH, 32'h5555_5555);
    send_request(OP_READ_MID, $urandom());
    send_request(OP_POP, $urandom());
    send_request(OP_DEL_MID, $urandom());
    send_request(OP_READ_MID, $urandom());
    send_request(OP_DEL_MID, $urandom());
    send_request(OP_DEL_MID, $urandom());
    send_request(OP_READ_MID, $urandom());
    send_request(OP_DEL_MID, $urandom());
    send_request(OP_POP, $urandom());
  endtask

  // Fill to capacity, push into a full stack, read and delete the middle from full depth, refill, then a random mix.
  task automatic test_full_stack();
    int k;
    while (shadow_count < DEPTH) send_request(OP_PUSH, $urandom());
    send_request(OP_PUSH, $urandom());
    send_request(OP_READ_MID, $urandom());
    for (k = 0; k < 4; k++) send_request(OP_DEL_MID, $urandom());
    while (shadow_count < DEPTH) send_request(OP_PUSH, $urandom());
    send_request(OP_PUSH, 32'hffff_ffff);
    run_random_mix(40, 10);
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_output_stall();
    hold_cycles = 300;
    run_random_mix(12, 50);
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_no_idle();
    use_gaps = 1'b0;
    run_random_mix(100, 55);
    use_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    run_random_mix(60, 45);
    run_random_mix(50, 75);
    run_random_mix(40, 15);
  endtask

  // Result side: random ready gaps, plus one long hold when requested.
  initial begin
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      gap = use_gaps ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Compare every accepted result with the oldest outcome owed.
  always @(posedge clk) begin
    stack_outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_outcomes.size() == 0) begin
        $display("[%0t] result with no request outstanding", $realtime);
        mismatch_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (m_tuser !== want.status)
          report_mismatch("status", m_tuser, want.status);
        if (m_tdata[VALUE_W-1:0] !== want.value)
          report_mismatch("result_value", m_tdata[VALUE_W-1:0], want.value);
        if (m_tdata[VALUE_W+NEW_COUNT_W-1:VALUE_W] !== want.count)
          report_mismatch("new_count", m_tdata[VALUE_W+NEW_COUNT_W-1:VALUE_W], want.count);
        if (m_tdata[OUT_DATA_W-1:VALUE_W+NEW_COUNT_W] !== '0)
          report_mismatch("pad", m_tdata[OUT_DATA_W-1:VALUE_W+NEW_COUNT_W], 0);
      end
    end
  end

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = OP_PUSH;
    m_tready       = 1'b0;
    shadow_count   = 0;
    mismatch_count = 0;
    use_gaps       = 1'b1;
    hold_cycles    = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_stack();
    test_middle_access();
    test_full_stack();
    test_output_stall();
    test_random_traffic();
    test_no_idle();
    test_full_stack();

    // Drain: wait for every owed result, then allow for a long delete.
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_outcomes.size() != 0);
    repeat (DEPTH) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("stack_with_middle_access_core verification clean");
    end else begin
      $display("stack_with_middle_access_core verification failed");
    end
    $finish;
  end

endmodule
